FILE: hdl/ccwr_pkg.sv
// Shared types and constants for the ranged carry-chain generator block.
// Used by every module in hdl/; depends on nothing else.
`default_nettype none

package ccwr_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 6;

   // Generator sequencing: five cascade adds, then seven rotate steps
   // (one plain realignment followed by six increment steps, low word first).
   localparam int CASCADE_STEPS = 5;
   localparam int GEN_STEPS     = 12;
   localparam int GEN_CNT_W     = $clog2(GEN_STEPS);

   // Remainder unit: one dividend bit per cycle.
   localparam int DIV_STEPS = WORD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Word values after reset, w0 first.
   localparam logic [WORD_W-1:0] RESET_WORDS [NUM_WORDS] = '{
      32'hF22D0E56, 32'h883126E9, 32'hC624DD2F,
      32'h0702C49C, 32'h9E353F7D, 32'h6FDF3B64
   };

   // Seed offsets.
   localparam logic [WORD_W-1:0] SEED_SUB0 = 32'h0DD2F1AA;
   localparam logic [WORD_W-1:0] SEED_SUB1 = 32'h77CED917;
   localparam logic [WORD_W-1:0] SEED_ADD2 = 32'h3DF3B646;
   localparam logic [WORD_W-1:0] SEED_ADD3 = 32'h7ED19DB3;
   localparam logic [WORD_W-1:0] SEED_ADD4 = 32'h16041894;
   localparam logic [WORD_W-1:0] SEED_ADD5 = 32'h6FDF3B64;

   // Folded offsets so each seeded word is a single add on the seed.
   localparam logic [WORD_W-1:0] SEED_OFS0 = -SEED_SUB0;
   localparam logic [WORD_W-1:0] SEED_OFS1 = -SEED_SUB1;
   localparam logic [WORD_W-1:0] SEED_OFS2 = SEED_ADD2 - SEED_SUB1;
   localparam logic [WORD_W-1:0] SEED_OFS3 = SEED_ADD3 - SEED_SUB1;
   localparam logic [WORD_W-1:0] SEED_OFS4 = SEED_ADD4 - SEED_SUB1;
   localparam logic [WORD_W-1:0] SEED_OFS5 = SEED_ADD5;

   typedef enum logic {
      OP_DRAW = 1'b0,
      OP_SEED = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GEN,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic seed_load;
      logic step_start;
   } gen_ctrl_type;

   typedef struct packed {
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

FILE: hdl/ccwr_gen.sv
// Generator word store with one shared 32-bit adder, stepped by rotation.
// Depends on ccwr_pkg.
`default_nettype none

module ccwr_gen (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ccwr_pkg::gen_ctrl_type      ctrl,
   input  wire logic [ccwr_pkg::WORD_W-1:0] seed_value,
   output logic      [ccwr_pkg::WORD_W-1:0] top_word,
   output ccwr_pkg::unit_status_type        status
);

   localparam int NW = ccwr_pkg::NUM_WORDS;

   logic [ccwr_pkg::WORD_W-1:0]  words_ff [NW];
   logic [ccwr_pkg::WORD_W-1:0]  words_in [NW];
   logic [ccwr_pkg::GEN_CNT_W-1:0] step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          carry_ff, carry_in;

   logic                          cascade;
   logic                          last_step;
   logic                          cin;
   logic                          carry_next;
   logic [ccwr_pkg::WORD_W-1:0]   op_a, op_b, sum;

   // Shared adder: cascade adds word 4 and word 5, rotate steps add carry to word 5
   always_comb begin
      cascade   = step_ff < ccwr_pkg::GEN_CNT_W'(ccwr_pkg::CASCADE_STEPS);
      last_step = step_ff == ccwr_pkg::GEN_CNT_W'(ccwr_pkg::GEN_STEPS - 1);
      op_a      = cascade ? words_ff[NW-2] : words_ff[NW-1];
      op_b      = cascade ? words_ff[NW-1] : '0;
      if (cascade) begin
         cin = carry_ff;
      end else if (step_ff == ccwr_pkg::GEN_CNT_W'(ccwr_pkg::CASCADE_STEPS)) begin
         cin = 1'b0;
      end else if (step_ff == ccwr_pkg::GEN_CNT_W'(ccwr_pkg::CASCADE_STEPS + 1)) begin
         cin = 1'b1;
      end else begin
         cin = carry_ff;
      end
      sum = op_a + op_b + ccwr_pkg::WORD_W'(cin);
      // Carry by compare only, as the generator defines it
      if (cascade) begin
         carry_next = (sum < op_a) || ((step_ff == '0) && (sum < op_b));
      end else begin
         carry_next = cin && (sum == '0);
      end
   end

   // Next word state: seed load, start, or one rotate step
   always_comb begin
      words_in = words_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      carry_in = carry_ff;
      if (ctrl.seed_load) begin
         words_in[0] = seed_value + ccwr_pkg::SEED_OFS0;
         words_in[1] = seed_value + ccwr_pkg::SEED_OFS1;
         words_in[2] = seed_value + ccwr_pkg::SEED_OFS2;
         words_in[3] = seed_value + ccwr_pkg::SEED_OFS3;
         words_in[4] = seed_value + ccwr_pkg::SEED_OFS4;
         words_in[5] = seed_value + ccwr_pkg::SEED_OFS5;
      end else if (ctrl.step_start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         carry_in = 1'b0;
      end else if (busy_ff) begin
         if (cascade) begin
            // new word lands at the low end, old low word wraps to the top
            words_in[NW-1] = sum;
            for (int i = 1; i < NW - 1; i++) begin
               words_in[i] = words_ff[i-1];
            end
            words_in[0] = words_ff[NW-1];
         end else begin
            // rotate right, incremented low word re-enters at the top
            words_in[0] = sum;
            for (int i = 1; i < NW; i++) begin
               words_in[i] = words_ff[i-1];
            end
         end
         step_in  = step_ff + 1'b1;
         carry_in = carry_next;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NW; i++) begin
            words_ff[i] <= ccwr_pkg::RESET_WORDS[i];
         end
         step_ff  <= '0;
         busy_ff  <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         words_ff <= words_in;
         step_ff  <= step_in;
         busy_ff  <= busy_in;
         carry_ff <= carry_in;
      end
   end

   assign top_word    = words_ff[0];
   assign status.done = busy_ff && last_step;

endmodule

`default_nettype wire

FILE: hdl/ccwr_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on ccwr_pkg.
`default_nettype none

module ccwr_rem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ccwr_pkg::WORD_W-1:0] dividend,
   input  wire logic [ccwr_pkg::WORD_W-1:0] divisor,
   output logic      [ccwr_pkg::WORD_W-1:0] remainder,
   output ccwr_pkg::unit_status_type        status
);

   localparam int W = ccwr_pkg::WORD_W;

   logic [W-1:0]                   rem_ff, quo_ff, div_ff;
   logic [ccwr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;

   logic [W:0]   trial;
   logic [W+1:0] diff;
   logic [W-1:0] rem_in;
   logic         last_bit;

   // Shift in the next dividend bit, subtract the divisor when it fits
   always_comb begin
      trial    = {rem_ff, quo_ff[W-1]};
      diff     = {1'b0, trial} - {2'b00, div_ff};
      rem_in   = diff[W+1] ? trial[W-1:0] : diff[W-1:0];
      last_bit = cnt_ff == ccwr_pkg::DIV_CNT_W'(ccwr_pkg::DIV_STEPS - 1);
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (last_bit) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[W-2:0], 1'b0};
      end
   end

   assign remainder   = rem_ff;
   assign status.done = busy_ff && last_bit;

endmodule

`default_nettype wire

FILE: hdl/carry_chain_word_rng_ranged_core.sv
// Top level of the ranged carry-chain generator: sequencer and result register.
// Depends on ccwr_pkg, ccwr_gen and ccwr_rem.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, opcode, seed, low/high | in
//   rsp     | rsp_valid/ready, value, raw_word        | out
//
// A seed word is taken and leaves req_ready high.
// A draw with zero span goes from acceptance straight to the finish state, then to the result register.
// Any other draw runs 12 generator steps through the single shared 32-bit adder,
// a load step, 32 steps of the bit-serial remainder unit, and a finish step.
// req_ready is low while a draw is in progress; a finished word waits in
// the result register while the next request is taken. Reset is synchronous.
`default_nettype none

module carry_chain_word_rng_ranged_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic        [ccwr_pkg::WORD_W-1:0] req_seed_value,
   input  wire logic signed [ccwr_pkg::WORD_W-1:0] req_range_low,
   input  wire logic signed [ccwr_pkg::WORD_W-1:0] req_range_high,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed      [ccwr_pkg::WORD_W-1:0] rsp_value,
   output logic             [ccwr_pkg::WORD_W-1:0] rsp_raw_word
);

   localparam int W = ccwr_pkg::WORD_W;

   ccwr_pkg::state_type       state_ff, state_in;
   logic [W-1:0]              lo_ff, span_ff;
   logic                      rsp_valid_ff;
   logic [W-1:0]              rsp_value_ff, rsp_raw_word_ff;

   logic                      req_fire;
   logic                      is_draw;
   logic [W-1:0]              span_req;
   logic                      span_zero;
   logic                      rsp_load;
   logic                      rem_start;
   ccwr_pkg::gen_ctrl_type    gen_ctrl;
   ccwr_pkg::unit_status_type gen_status, rem_status;
   logic [W-1:0]              gen_top_word;
   logic [W-1:0]              remainder;

   assign req_fire  = req_valid && req_ready;
   assign is_draw   = ccwr_pkg::opcode_type'(req_opcode) == ccwr_pkg::OP_DRAW;
   assign span_req  = $unsigned(req_range_high) - $unsigned(req_range_low) + W'(1);
   assign span_zero = span_req == '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccwr_pkg::ST_IDLE: begin
            if (req_fire && is_draw) begin
               state_in = span_zero ? ccwr_pkg::ST_DONE : ccwr_pkg::ST_GEN;
            end
         end
         ccwr_pkg::ST_GEN: begin
            if (gen_status.done) begin
               state_in = ccwr_pkg::ST_DIV_START;
            end
         end
         ccwr_pkg::ST_DIV_START: begin
            state_in = ccwr_pkg::ST_DIV;
         end
         ccwr_pkg::ST_DIV: begin
            if (rem_status.done) begin
               state_in = ccwr_pkg::ST_DONE;
            end
         end
         ccwr_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = ccwr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccwr_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready           = state_ff == ccwr_pkg::ST_IDLE;
      gen_ctrl.seed_load  = req_fire && !is_draw;
      gen_ctrl.step_start = req_fire && is_draw && !span_zero;
      rem_start           = state_ff == ccwr_pkg::ST_DIV_START;
      rsp_load            = (state_ff == ccwr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccwr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the draw bounds
   always_ff @(posedge clock) begin
      if (req_fire && is_draw) begin
         lo_ff   <= $unsigned(req_range_low);
         span_ff <= span_req;
      end
   end

   ccwr_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (gen_ctrl),
      .seed_value (req_seed_value),
      .top_word   (gen_top_word),
      .status     (gen_status)
   );

   ccwr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (gen_top_word),
      .divisor   (span_ff),
      .remainder (remainder),
      .status    (rem_status)
   );

   // Result register: zero span gives low minus one, which is high
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff    <= lo_ff + ((span_ff == '0) ? '1 : remainder);
         rsp_raw_word_ff <= gen_top_word;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = $signed(rsp_value_ff);
   assign rsp_raw_word = rsp_raw_word_ff;

endmodule

`default_nettype wire

FILE: hdl/ccwr_checker.sv
// Port-level checks for the ranged carry-chain generator, bound to its top level.
// Depends on ccwr_pkg and carry_chain_word_rng_ranged_core.
`default_nettype none

module ccwr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               req_opcode,
   input wire logic signed [ccwr_pkg::WORD_W-1:0] req_range_low,
   input wire logic signed [ccwr_pkg::WORD_W-1:0] req_range_high,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [ccwr_pkg::WORD_W-1:0] rsp_value,
   input wire logic        [ccwr_pkg::WORD_W-1:0] rsp_raw_word
);

   logic req_fire;
   logic seed_seen;
   assign req_fire  = req_valid && req_ready;
   assign seed_seen = req_fire && (req_opcode == ccwr_pkg::OP_SEED);

   // Drop any pending word on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_raw_word))
      else $error("stalled result word changed");

   // A seed word leaves the block ready
   a_seed_ready: assert property (@(posedge clock) disable iff (reset)
      seed_seen |=> req_ready)
      else $error("not ready after seed word");

   // A draw word makes the block busy
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == ccwr_pkg::OP_DRAW) |=> !req_ready)
      else $error("ready right after draw word");

   // Zero span with an empty result register returns high by way of the finish state
   a_zero_span: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == ccwr_pkg::OP_DRAW) && !rsp_valid
      && (req_range_low == req_range_high + 32'sd1)
      |=> ##1 rsp_valid && (rsp_value == $past(req_range_high, 2)))
      else $error("zero span draw did not return high");

endmodule

bind carry_chain_word_rng_ranged_core ccwr_checker u_ccwr_checker (.*);

`default_nettype wire
